### src/assert_macros.svh
// assertion macros used by the top module
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/kbd_pkg.sv
// types, codes and scan code tables for the keyboard scan code decoder
// no dependencies; used by kbd_front, kbd_opq, kbd_back and the top module
`timescale 1ns / 1ps

package kbd_pkg;

  localparam int CMD_QUEUE_DEPTH = 32;

  localparam logic [1:0] ACT_SCAN = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_INIT = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [7:0] SC_ENTER       = 8'h1c;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0e;
  localparam logic [7:0] SC_CAPS        = 8'h3a;
  localparam logic [7:0] SC_NUM         = 8'h45;
  localparam logic [7:0] SC_SCROLL      = 8'h46;
  localparam logic [7:0] SC_LSHIFT      = 8'h2a;
  localparam logic [7:0] SC_RSHIFT      = 8'h36;
  localparam logic [7:0] SC_LSHIFT_UP   = 8'haa;
  localparam logic [7:0] SC_RSHIFT_UP   = 8'hb6;
  localparam logic [7:0] SC_ACK         = 8'hfa;
  localparam logic [7:0] SC_RESEND      = 8'hfe;

  localparam logic [7:0] CMD_SET_LEDS   = 8'hed;
  localparam logic [7:0] CHAR_LF        = 8'h0a;
  localparam logic [7:0] CHAR_BS        = 8'h08;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  localparam logic [0:0] KIND_CHAR = 1'b0;
  localparam logic [0:0] KIND_CMD  = 1'b1;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_code;
    logic       led_cmd;
    logic [2:0] leds;
    logic       ack;
    logic       resend;
  } op_t;

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_MAP [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

endpackage

### src/kbd_ram.sv
// generic single write port ram with registered read
// no dependencies; holds the keyboard command byte queue
`timescale 1ns / 1ps

module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/kbd_front.sv
// front end: accepts input items, decodes scan codes, tracks shift and lock keys
// depends on kbd_pkg; pushes one classified request per item, except ACT_NONE items, into kbd_opq
`timescale 1ns / 1ps

module kbd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       action,
  input  logic [7:0]       scancode,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_data,
  input  logic             full,
  output logic             in_stall,
  output logic             push,
  output kbd_pkg::op_t     op
);

  logic [1:0] shift_keys;
  logic [1:0] shift_keys_next;
  logic [2:0] lock_leds;
  logic [2:0] lock_leds_next;
  logic [2:0] init_leds;
  logic       accept;
  logic       is_scan;
  logic [7:0] raw_char;
  logic [7:0] ch;
  logic       caps;
  logic       shifted;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && (action != kbd_pkg::ACT_NONE);
  assign is_scan  = (action == kbd_pkg::ACT_SCAN);
  assign caps     = lock_leds[2];
  assign shifted  = (shift_keys != 2'b00);

  always_comb begin
    if (scancode[7]) begin
      raw_char = 8'h00;
    end else if (shifted) begin
      raw_char = kbd_pkg::SHIFTED_MAP[scancode[6:0]];
    end else begin
      raw_char = kbd_pkg::PLAIN_MAP[scancode[6:0]];
    end
    ch = raw_char;
    if ((raw_char inside {[kbd_pkg::CHAR_UPPER_A:kbd_pkg::CHAR_UPPER_Z]}) &&
        (caps == shifted)) begin
      ch = raw_char + kbd_pkg::CASE_OFFSET;
    end
  end

  always_comb begin
    shift_keys_next = shift_keys;
    lock_leds_next  = lock_leds;
    op              = '0;
    case (action)
      kbd_pkg::ACT_SCAN: begin
        case (scancode)
          kbd_pkg::SC_CAPS:      lock_leds_next = lock_leds ^ kbd_pkg::LED_CAPS;
          kbd_pkg::SC_NUM:       lock_leds_next = lock_leds ^ kbd_pkg::LED_NUM;
          kbd_pkg::SC_SCROLL:    lock_leds_next = lock_leds ^ kbd_pkg::LED_SCROLL;
          kbd_pkg::SC_LSHIFT:    shift_keys_next = shift_keys | 2'b01;
          kbd_pkg::SC_RSHIFT:    shift_keys_next = shift_keys | 2'b10;
          kbd_pkg::SC_LSHIFT_UP: shift_keys_next = shift_keys & 2'b10;
          kbd_pkg::SC_RSHIFT_UP: shift_keys_next = shift_keys & 2'b01;
          default: ;
        endcase
        op.led_cmd = (scancode inside {kbd_pkg::SC_CAPS, kbd_pkg::SC_NUM,
                                       kbd_pkg::SC_SCROLL});
      end
      kbd_pkg::ACT_INIT: begin
        lock_leds_next = init_leds;
        op.led_cmd     = 1'b1;
      end
      default: ;
    endcase
    op.has_char = is_scan && ((ch != 8'h00) || (scancode == kbd_pkg::SC_ENTER) ||
                              (scancode == kbd_pkg::SC_BACKSPACE));
    if (ch != 8'h00) begin
      op.char_code = ch;
    end else if (scancode == kbd_pkg::SC_ENTER) begin
      op.char_code = kbd_pkg::CHAR_LF;
    end else begin
      op.char_code = kbd_pkg::CHAR_BS;
    end
    op.leds   = lock_leds_next;
    op.ack    = is_scan && (scancode == kbd_pkg::SC_ACK);
    op.resend = is_scan && (scancode == kbd_pkg::SC_RESEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_keys <= 2'b00;
      lock_leds  <= 3'b000;
      init_leds  <= 3'b000;
    end else begin
      if (cfg_valid) begin
        init_leds <= cfg_data;
      end
      if (push) begin
        shift_keys <= shift_keys_next;
        lock_leds  <= lock_leds_next;
      end
    end
  end

endmodule

### src/kbd_opq.sv
// two-entry request queue between front and back
// depends on kbd_pkg for the request type
`timescale 1ns / 1ps

module kbd_opq (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  kbd_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         op_valid,
  output kbd_pkg::op_t op
);

  kbd_pkg::op_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign op_valid = (fill != 2'd0);
  assign op       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/kbd_back.sv
// back end: runs the led command queue, acknowledge and resend, drives results
// depends on kbd_pkg and kbd_ram; takes requests from kbd_opq
`timescale 1ns / 1ps

module kbd_back #(
  parameter int CMD_QUEUE_DEPTH = kbd_pkg::CMD_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  kbd_pkg::op_t op,
  output logic         op_take,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         kind,
  output logic [7:0]   value,
  output logic [2:0]   lock_state,
  output logic         last
);

  localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(CMD_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_QUEUE_DEPTH);

  localparam logic [1:0] ST_DECODE = 2'd0;
  localparam logic [1:0] ST_LED    = 2'd1;
  localparam logic [1:0] ST_POP    = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             awaiting;
  logic             awaiting_next;
  logic [7:0]       pending_byte;
  logic [7:0]       pending_byte_next;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             poll_q;
  logic             bypass_q;
  logic [2:0]       leds_q;

  logic             can_emit;
  logic             emit;
  logic             emit_kind;
  logic [7:0]       emit_value;
  logic [2:0]       emit_leds;
  logic             emit_last;

  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  logic             awaiting_eff;
  logic             resend_now;
  logic             poll_now;
  logic             decode_emit;
  logic             has_room;
  logic [7:0]       pop_value;

  assign can_emit     = !out_valid || !out_stall;
  assign awaiting_eff = op.ack ? 1'b0 : awaiting;
  assign resend_now   = op.resend && awaiting;
  assign poll_now     = !awaiting_eff && ((count != '0) || op.led_cmd);
  assign decode_emit  = op.has_char || resend_now;
  assign has_room     = (count < CNT_FULL);
  assign pop_value    = bypass_q ? kbd_pkg::CMD_SET_LEDS : ram_rdata;

  always_comb begin
    state_next        = state;
    awaiting_next     = awaiting;
    pending_byte_next = pending_byte;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    op_take           = 1'b0;
    ram_we            = 1'b0;
    ram_wdata         = kbd_pkg::CMD_SET_LEDS;
    ram_re            = 1'b0;
    emit              = 1'b0;
    emit_kind         = kbd_pkg::KIND_CHAR;
    emit_value        = op.char_code;
    emit_leds         = op.leds;
    emit_last         = 1'b1;
    case (state)
      ST_DECODE: begin
        if (op_valid && (!decode_emit || can_emit)) begin
          op_take       = 1'b1;
          awaiting_next = awaiting_eff;
          ram_re        = 1'b1;
          if (op.led_cmd && has_room) begin
            ram_we     = 1'b1;
            tail_next  = (tail == PTR_MAX) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
          emit      = decode_emit;
          emit_last = !poll_now;
          if (resend_now) begin
            emit_kind  = kbd_pkg::KIND_CMD;
            emit_value = pending_byte;
          end
          if (op.led_cmd) begin
            state_next = ST_LED;
          end else if (poll_now) begin
            state_next = ST_POP;
          end
        end
      end
      ST_LED, ST_POP: begin
        if (!poll_q || can_emit) begin
          state_next = ST_DECODE;
          if ((state == ST_LED) && has_room) begin
            ram_we     = 1'b1;
            ram_wdata  = {5'b00000, leds_q};
            tail_next  = (tail == PTR_MAX) ? '0 : tail + 1'b1;
          end
          count_next = count + CNT_W'(ram_we) - CNT_W'(poll_q);
          if (poll_q) begin
            head_next         = (head == PTR_MAX) ? '0 : head + 1'b1;
            awaiting_next     = 1'b1;
            pending_byte_next = pop_value;
            emit              = 1'b1;
            emit_kind         = kbd_pkg::KIND_CMD;
            emit_value        = pop_value;
            emit_leds         = leds_q;
          end
        end
      end
      default: state_next = ST_DECODE;
    endcase
  end

  kbd_ram #(
    .WIDTH(8),
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (op_take) begin
      poll_q   <= poll_now;
      bypass_q <= (count == '0);
      leds_q   <= op.leds;
    end
    if (emit) begin
      kind       <= emit_kind;
      value      <= emit_value;
      lock_state <= emit_leds;
      last       <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_DECODE;
      awaiting     <= 1'b0;
      pending_byte <= 8'h00;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      awaiting     <= awaiting_next;
      pending_byte <= pending_byte_next;
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/keyboard_scancode_decoder.sv
// keyboard scan code decoder: a request goes through the request queue, and a character or
// resend result is registered when taken; a led command queue byte from the led or pop state
// throughput: one input request per cycle while in_stall is low; a lock key, an init request
// or a request sending a queued byte holds the back end in the led or pop state (second write, pop)
// results leave one per cycle while out_stall is low, through a registered output stage
// synchronous active-high reset clears shift, locks, queue pointers and ack state
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keyboard_scancode_decoder #(
  parameter int CMD_QUEUE_DEPTH = kbd_pkg::CMD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] value,
  output logic [2:0] lock_state,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  kbd_pkg::op_t push_op;
  kbd_pkg::op_t op;
  logic         push;
  logic         full;
  logic         op_valid;
  logic         op_take;

  assign cfg_ready = 1'b1;

  kbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .scancode (scancode),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .full     (full),
    .in_stall (in_stall),
    .push     (push),
    .op       (push_op)
  );

  kbd_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (op_take),
    .op_valid(op_valid),
    .op      (op)
  );

  kbd_back #(
    .CMD_QUEUE_DEPTH(CMD_QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .lock_state(lock_state),
    .last      (last)
  );

  `ASSERT_IMPLY(a_take_nonempty, clk, rst, op_take, op_valid, "back took from empty queue")
  `ASSERT_IMPLY(a_char_nonzero, clk, rst, out_valid && (kind == kbd_pkg::KIND_CHAR),
                value != 8'h00, "character result is zero")
  `ASSERT_NEXT(a_second_follows, clk, rst, out_valid && !out_stall && !last, out_valid,
               "second result of a request did not follow")
  `ASSERT_NEXT(a_request_held, clk, rst, op_valid && !op_take, op_valid,
               "queued request vanished")

endmodule
